### hw/rtl/upc_pkg.sv
// Shared types, constants and the one's-complement adder for the UDP checksum unit.
// No dependencies; every other file of the block but upc_checker imports this package.
`timescale 1ns / 1ps
package upc_pkg;

  localparam logic [15:0] ALL_ONES    = 16'hFFFF;
  localparam logic [15:0] UDP_PROTO   = 16'd17;
  localparam logic [15:0] LEN_OFFSET  = 16'd4;
  localparam logic [15:0] CSUM_OFFSET = 16'd6;
  localparam logic        REQ_CHECK   = 1'b1;

  // One classified word as it travels from the front end to the accumulator.
  typedef struct packed {
    logic [15:0] add_value;  // amount to add into the running sum
    logic        last;       // final word of the packet
    logic [15:0] tail_sum;   // length field plus protocol, already folded
    logic        op_check;   // packet is in check mode
    logic        ipv6;       // packet uses the IPv6 pseudo-header
    logic        csum_zero;  // stored checksum word was zero
    logic        short_seg;  // fewer segment bytes than the length field
  } upc_entry_t;

  // 16-bit one's-complement add with end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + 16'(s[16]);
  endfunction

endpackage

### hw/rtl/udp_pseudo_header_checksum_unit.sv
// UDP checksum over an IPv4/IPv6 pseudo-header, one 16-bit word per cycle while the queue has room.
// Throughput: one word per cycle while the queue has room; the accumulator does one folded add per word.
// A packet's last word passes through the queue and then the result register before out_valid rises.
// Reset: synchronous, active-high rst clears packet state, the queue and out_valid.
// Depends on upc_pkg, upc_front, upc_fifo and upc_back.
`timescale 1ns / 1ps
module udp_pseudo_header_checksum_unit import upc_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic        is_ipv6,
  input  logic        addr_word,
  input  logic [15:0] data_word,
  input  logic        odd_tail,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] checksum_value,
  output logic        check_failed,
  output logic        length_short
);

  // The front end classifies each word as it is accepted: it tracks the
  // segment byte offset, latches the length field, notes a zero stored
  // checksum and decides how much of the word belongs in the sum. Its
  // output goes straight into the queue, so a word is taken whenever the
  // queue has room, even while a finished result waits at the output.

  upc_entry_t front_entry;
  upc_entry_t q_entry;
  logic       push;
  logic       q_full;
  logic       q_valid;
  logic       pop;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  upc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .req_type  (req_type),
    .is_ipv6   (is_ipv6),
    .addr_word (addr_word),
    .data_word (data_word),
    .odd_tail  (odd_tail),
    .last      (last),
    .entry     (front_entry)
  );

  // The queue lets the front end keep accepting words while the back end
  // holds a last word because the previous result has not been taken.
  upc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (front_entry),
    .full       (q_full),
    .pop        (pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_entry)
  );

  // The back end folds each word into the running sum and, on the last
  // word, adds the pseudo-header tail and registers the result word.
  upc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_entry        (q_entry),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .checksum_value (checksum_value),
    .check_failed   (check_failed),
    .length_short   (length_short)
  );

endmodule

### hw/rtl/upc_front.sv
// Front end of the UDP checksum unit: tracks packet position and classifies each word.
// Depends on upc_pkg.
`timescale 1ns / 1ps
module upc_front import upc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        req_type,
  input  logic        is_ipv6,
  input  logic        addr_word,
  input  logic [15:0] data_word,
  input  logic        odd_tail,
  input  logic        last,
  output upc_entry_t  entry
);

  logic        in_packet;
  logic        op_is_check;
  logic        mode_ipv6;
  logic [15:0] segment_bytes;
  logic [15:0] length_value;
  logic        stored_sum_zero;

  logic        first;
  logic        op_cur;
  logic        ipv6_cur;
  logic [15:0] off;
  logic [15:0] len_cur;
  logic        ssz_cur;
  logic [15:0] word;
  logic [15:0] add_value;
  logic [15:0] len_next;
  logic        ssz_next;
  logic [15:0] seg_next;
  logic [16:0] seg_sum;

  // A word arriving outside a packet starts a new one and sees cleared state.
  assign first    = !in_packet;
  assign op_cur   = first ? (req_type == REQ_CHECK) : op_is_check;
  assign ipv6_cur = first ? is_ipv6 : mode_ipv6;
  assign off      = first ? 16'd0 : segment_bytes;
  assign len_cur  = first ? 16'd0 : length_value;
  assign ssz_cur  = first ? 1'b0 : stored_sum_zero;
  assign word     = odd_tail ? {data_word[15:8], 8'h00} : data_word;
  assign seg_sum  = {1'b0, off} + (odd_tail ? 17'd1 : 17'd2);

  always_comb begin
    add_value = word;
    len_next  = len_cur;
    ssz_next  = ssz_cur;
    seg_next  = off;
    if (!addr_word) begin
      if (off == LEN_OFFSET) begin
        len_next = word;
      end
      if (off == CSUM_OFFSET) begin
        ssz_next = (word == 16'd0);
        if (!op_cur) begin
          add_value = 16'd0;
        end
      end
      // From the checksum word on, only bytes below the length field are summed.
      if (off >= CSUM_OFFSET) begin
        if (off >= len_cur) begin
          add_value = 16'd0;
        end else if (({1'b0, off} + 17'd1) == {1'b0, len_cur}) begin
          add_value = {add_value[15:8], 8'h00};
        end
      end
      seg_next = seg_sum[16] ? ALL_ONES : seg_sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet       <= 1'b0;
      op_is_check     <= 1'b0;
      mode_ipv6       <= 1'b0;
      segment_bytes   <= 16'd0;
      length_value    <= 16'd0;
      stored_sum_zero <= 1'b0;
    end else if (push) begin
      in_packet       <= !last;
      op_is_check     <= op_cur;
      mode_ipv6       <= ipv6_cur;
      segment_bytes   <= seg_next;
      length_value    <= len_next;
      stored_sum_zero <= ssz_next;
    end
  end

  assign entry.add_value = add_value;
  assign entry.last      = last;
  assign entry.tail_sum  = oc_add(len_next, UDP_PROTO);
  assign entry.op_check  = op_cur;
  assign entry.ipv6      = ipv6_cur;
  assign entry.csum_zero = ssz_next;
  assign entry.short_seg = (seg_next < len_next);

endmodule

### hw/rtl/upc_fifo.sv
// Small register FIFO that decouples the front end from the accumulator.
// Depends on upc_pkg for the entry type.
`timescale 1ns / 1ps
module upc_fifo import upc_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  upc_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       pop_valid,
  output upc_entry_t pop_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  upc_entry_t         slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/upc_back.sv
// Accumulator and result stage of the UDP checksum unit.
// Depends on upc_pkg for the entry type and the one's-complement adder.
`timescale 1ns / 1ps
module upc_back import upc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  upc_entry_t  q_entry,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] checksum_value,
  output logic        check_failed,
  output logic        length_short
);

  logic [15:0] running_sum;
  logic [15:0] sum_word;
  logic [15:0] sum_total;
  logic [15:0] csum;

  // Only a last word needs the result register to be free.
  assign pop       = q_valid && (!q_entry.last || !out_valid || out_ready);
  assign sum_word  = oc_add(running_sum, q_entry.add_value);
  assign sum_total = oc_add(sum_word, q_entry.tail_sum);
  assign csum      = ~sum_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= 16'd0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        running_sum <= q_entry.last ? 16'd0 : sum_word;
      end
      if (pop && q_entry.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_entry.last) begin
      length_short <= q_entry.short_seg;
      if (q_entry.op_check) begin
        checksum_value <= csum;
        check_failed   <= q_entry.csum_zero ? q_entry.ipv6 : (csum != 16'd0);
      end else begin
        checksum_value <= (csum == 16'd0) ? ALL_ONES : csum;
        check_failed   <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/upc_checker.sv
// Port-level checks for the UDP checksum unit, bound to the top level.
// No package dependency; sees only the top-level ports.
`timescale 1ns / 1ps
module upc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] checksum_value,
  input logic        check_failed,
  input logic        length_short
);

  // Reset empties the queue and the result register.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("reset did not clear out_valid or in_ready");

  // A held result word must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(checksum_value)
                                   && $stable(check_failed) && $stable(length_short)))
    else $error("result word changed while stalled");

  // The queue only fills through accepted words.
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(in_ready)) |-> $past(in_valid))
    else $error("in_ready dropped without an accepted word");

endmodule

bind udp_pseudo_header_checksum_unit upc_checker u_checker (.*);

### sim/tb_top.sv
// Self-checking testbench for udp_pseudo_header_checksum_unit: directed packets and random
// packet streams under several idle and stall patterns.
// Depends on upc_pkg and the unit's RTL.
`timescale 1ns / 1ps
module tb_top;
  import upc_pkg::*;

  localparam logic REQ_COMPUTE = 1'b0;
  localparam int   STALL_LIMIT = 2000;

  typedef struct packed {
    logic        req_type;
    logic        is_ipv6;
    logic        addr_word;
    logic [15:0] data_word;
    logic        odd_tail;
    logic        last;
  } pkt_word_t;

  typedef struct packed {
    logic [15:0] checksum_value;
    logic        check_failed;
    logic        length_short;
  } csum_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = 1'b0;
  logic        is_ipv6 = 1'b0;
  logic        addr_word = 1'b0;
  logic [15:0] data_word = 16'h0000;
  logic        odd_tail = 1'b0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] checksum_value;
  logic        check_failed;
  logic        length_short;

  pkt_word_t    word_q[$];
  csum_result_t expected_q[$];
  pkt_word_t    next_word;

  logic in_taken = 1'b0;
  logic open_packet = 1'b0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   idle_cycles = 0;
  int   mismatches = 0;
  int   words_queued = 0;
  int   packets_closed = 0;
  int   results_checked = 0;

  // Predicted state of the unit, one packet at a time.
  logic [15:0] acc_sum = 16'h0000;
  logic [15:0] seg_count = 16'h0000;
  logic [15:0] len_field = 16'h0000;
  logic        csum_was_zero = 1'b0;
  logic        pkt_check = 1'b0;
  logic        pkt_v6 = 1'b0;
  logic        mid_packet = 1'b0;

  udp_pseudo_header_checksum_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .is_ipv6        (is_ipv6),
    .addr_word      (addr_word),
    .data_word      (data_word),
    .odd_tail       (odd_tail),
    .last           (last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .checksum_value (checksum_value),
    .check_failed   (check_failed),
    .length_short   (length_short)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + {15'b0, t[16]};
  endfunction

  // Follows one accepted word; on the packet's last word it queues the expected result.
  task automatic absorb_word(input pkt_word_t w);
    logic [15:0]  val;
    logic [15:0]  add_val;
    logic [15:0]  total;
    logic [15:0]  inv;
    logic [16:0]  off;
    logic [16:0]  nxt;
    csum_result_t r;
    if (!mid_packet) begin
      pkt_check = w.req_type;
      pkt_v6 = w.is_ipv6;
      acc_sum = 16'h0000;
      seg_count = 16'h0000;
      len_field = 16'h0000;
      csum_was_zero = 1'b0;
    end
    val = w.odd_tail ? {w.data_word[15:8], 8'h00} : w.data_word;
    if (w.addr_word) begin
      acc_sum = ones_add(acc_sum, val);
    end else begin
      off = {1'b0, seg_count};
      add_val = val;
      if (off == {1'b0, LEN_OFFSET}) len_field = val;
      if (off == {1'b0, CSUM_OFFSET}) begin
        csum_was_zero = (val == 16'h0000);
        if (pkt_check != REQ_CHECK) add_val = 16'h0000;
      end
      // Bytes past the length field are not part of the segment.
      if (off >= {1'b0, CSUM_OFFSET}) begin
        if (off >= {1'b0, len_field}) add_val = 16'h0000;
        else if (off + 17'd1 == {1'b0, len_field}) add_val[7:0] = 8'h00;
      end
      acc_sum = ones_add(acc_sum, add_val);
      nxt = off + (w.odd_tail ? 17'd1 : 17'd2);
      seg_count = nxt[16] ? ALL_ONES : nxt[15:0];
    end
    if (!w.last) begin
      mid_packet = 1'b1;
    end else begin
      mid_packet = 1'b0;
      total = ones_add(ones_add(acc_sum, len_field), UDP_PROTO);
      inv = ~total;
      if (pkt_check == REQ_CHECK) begin
        r.checksum_value = inv;
        r.check_failed = csum_was_zero ? pkt_v6 : (inv != 16'h0000);
      end else begin
        r.checksum_value = (inv == 16'h0000) ? ALL_ONES : inv;
        r.check_failed = 1'b0;
      end
      r.length_short = (seg_count < len_field);
      expected_q.push_back(r);
      packets_closed++;
    end
  endtask

  // Mode and IP version only matter on a packet's first word, so later words get noise there.
  task automatic push_word(input logic req, input logic v6, input logic addr,
                           input logic [15:0] data, input logic odd, input logic fin);
    pkt_word_t w;
    w.req_type = open_packet ? 1'($urandom_range(1)) : req;
    w.is_ipv6 = open_packet ? 1'($urandom_range(1)) : v6;
    w.addr_word = addr;
    w.data_word = data;
    w.odd_tail = odd;
    w.last = fin;
    open_packet = !fin;
    words_queued++;
    word_q.push_back(w);
  endtask

  function automatic logic [15:0] pick_data();
    int k;
    k = $urandom_range(15);
    if (k == 0) return 16'h0000;
    if (k == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // A well-formed packet: address words, ports, length, checksum, payload.
  task automatic queue_packet(input logic req, input logic v6, input int n_pay,
                              input logic odd_end);
    logic [15:0] addr_w[$];
    logic [15:0] pay[$];
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] len;
    logic [15:0] csum;
    logic [15:0] sum;
    int          nbytes;
    int          k;
    logic        odd_last;
    odd_last = odd_end && (n_pay > 0);
    sport = pick_data();
    dport = pick_data();
    sum = 16'h0000;
    for (int i = 0; i < (v6 ? 16 : 4); i++) begin
      addr_w.push_back(pick_data());
      sum = ones_add(sum, addr_w[i]);
    end
    for (int i = 0; i < n_pay; i++) begin
      pay.push_back(pick_data());
      if (odd_last && i == n_pay - 1) pay[i][7:0] = 8'h00;
    end
    nbytes = 8 + 2 * n_pay - (odd_last ? 1 : 0);
    k = $urandom_range(9);
    if (k <= 6) len = 16'(nbytes);
    else if (k == 7) len = 16'($urandom);
    else if (k == 8) len = 16'(nbytes + $urandom_range(1, 4));
    else len = 16'($urandom_range(0, nbytes));
    sum = ones_add(sum, sport);
    sum = ones_add(sum, dport);
    sum = ones_add(sum, len);
    foreach (pay[i]) sum = ones_add(sum, pay[i]);
    sum = ones_add(ones_add(sum, len), UDP_PROTO);
    k = $urandom_range(9);
    if (req == REQ_CHECK && k <= 5) csum = (~sum == 16'h0000) ? ALL_ONES : ~sum;
    else if (k == 6) csum = 16'h0000;
    else csum = 16'($urandom);
    foreach (addr_w[i]) push_word(req, v6, 1'b1, addr_w[i], 1'b0, 1'b0);
    push_word(req, v6, 1'b0, sport, 1'b0, 1'b0);
    push_word(req, v6, 1'b0, dport, 1'b0, 1'b0);
    push_word(req, v6, 1'b0, len, 1'b0, 1'b0);
    push_word(req, v6, 1'b0, csum, 1'b0, n_pay == 0);
    foreach (pay[i]) begin
      push_word(req, v6, 1'b0, pay[i] | (odd_last && i == n_pay - 1 ? 16'($urandom) & 16'h00FF
                : 16'h0000), odd_last && i == n_pay - 1, i == n_pay - 1);
    end
  endtask

  // Short packets with random flags: stray address words, odd tails mid-packet, often no length word.
  task automatic queue_noise();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      push_word(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom_range(2) == 0,
                pick_data(), $urandom_range(3) == 0, i == n - 1);
    end
  endtask

  task automatic queue_random(input int n_words);
    int stop_at;
    stop_at = words_queued + n_words;
    while (words_queued < stop_at) begin
      if ($urandom_range(4) == 0) queue_noise();
      else queue_packet(1'($urandom_range(1)), $urandom_range(3) == 0, $urandom_range(0, 8),
                        1'($urandom_range(1)));
    end
  endtask

  // The sender holds off here until every expected result has come back.
  task automatic drain();
    while (word_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
  endtask

  // Driver: new payload only after the previous word was taken; all changes at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_word = word_q.pop_front();
          in_valid <= 1'b1;
          req_type <= next_word.req_type;
          is_ipv6 <= next_word.is_ipv6;
          addr_word <= next_word.addr_word;
          data_word <= next_word.data_word;
          odd_tail <= next_word.odd_tail;
          last <= next_word.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts on accepted input words and checks accepted results.
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_taken <= in_valid && in_ready;
      // A result with nothing pending is not progress, so a runaway output still times out.
      if ((in_valid && in_ready) || (out_valid && out_ready && expected_q.size() != 0))
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_valid && in_ready) begin
        absorb_word({req_type, is_ipv6, addr_word, data_word, odd_tail, last});
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no packet pending: checksum_value %h", checksum_value);
          mismatches++;
        end else begin
          if (checksum_value !== expected_q[0].checksum_value) begin
            $error("checksum_value: expected %h, got %h",
                   expected_q[0].checksum_value, checksum_value);
            mismatches++;
          end
          if (check_failed !== expected_q[0].check_failed) begin
            $error("check_failed: expected %b, got %b", expected_q[0].check_failed, check_failed);
            mismatches++;
          end
          if (length_short !== expected_q[0].length_short) begin
            $error("length_short: expected %b, got %b", expected_q[0].length_short, length_short);
            mismatches++;
          end
          void'(expected_q.pop_front());
          results_checked++;
        end
      end
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed packets, no idling.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // A lone segment word whose checksum comes out zero, which is sent as all ones.
    push_word(REQ_COMPUTE, 1'b0, 1'b0, 16'hFFEE, 1'b0, 1'b1);
    // A lone address word in check mode over IPv6.
    push_word(REQ_CHECK, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b1);
    // Zero stored checksum: passes for IPv4, fails for IPv6.
    for (int v = 0; v < 2; v++) begin
      push_word(REQ_CHECK, 1'(v), 1'b0, 16'hFFFF, 1'b0, 1'b0);
      push_word(REQ_CHECK, 1'(v), 1'b0, 16'h0000, 1'b0, 1'b0);
      push_word(REQ_CHECK, 1'(v), 1'b0, 16'h0008, 1'b0, 1'b0);
      push_word(REQ_CHECK, 1'(v), 1'b0, 16'h0000, 1'b0, 1'b1);
    end
    // Length 9 with an odd tail mid-packet, then a word beyond the length.
    push_word(REQ_COMPUTE, 1'b0, 1'b0, 16'hFFFF, 1'b0, 1'b0);
    push_word(REQ_COMPUTE, 1'b0, 1'b0, 16'hFFFF, 1'b0, 1'b0);
    push_word(REQ_COMPUTE, 1'b0, 1'b0, 16'h0009, 1'b0, 1'b0);
    push_word(REQ_COMPUTE, 1'b0, 1'b0, 16'hABCD, 1'b0, 1'b0);
    push_word(REQ_COMPUTE, 1'b0, 1'b0, 16'h12EF, 1'b1, 1'b0);
    push_word(REQ_COMPUTE, 1'b0, 1'b0, 16'hFFFF, 1'b0, 1'b1);
    // Length field far beyond what arrives.
    push_word(REQ_CHECK, 1'b0, 1'b1, 16'hFFFF, 1'b0, 1'b0);
    push_word(REQ_CHECK, 1'b0, 1'b0, 16'h1234, 1'b0, 1'b0);
    push_word(REQ_CHECK, 1'b0, 1'b0, 16'h5678, 1'b0, 1'b0);
    push_word(REQ_CHECK, 1'b0, 1'b0, 16'hFFFF, 1'b0, 1'b0);
    push_word(REQ_CHECK, 1'b0, 1'b0, 16'h1234, 1'b0, 1'b1);
    drain();

    queue_random(150);
    drain();

    send_idle_pct = 55;
    recv_stall_pct = 0;
    queue_random(150);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 55;
    queue_random(150);
    drain();

    send_idle_pct = 7;
    recv_stall_pct = 7;
    queue_random(150);
    drain();

    repeat (10) @(posedge clk);
    $display("Sent %0d words forming %0d packets; %0d results checked, %0d mismatches.",
             words_queued, packets_closed, results_checked, mismatches);
    $display("Covered directed corner packets and random streams in four pacing phases.");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/upc_pkg.sv
hw/rtl/upc_front.sv
hw/rtl/upc_fifo.sv
hw/rtl/upc_back.sv
hw/rtl/udp_pseudo_header_checksum_unit.sv
hw/rtl/upc_checker.sv
sim/tb_top.sv
